>>> sv/rgsr_pkg.sv
package rgsr_pkg;

  localparam int SCALE_FRAC_BITS = 16;
  localparam int DB_FRAC_BITS    = 8;

  localparam int GAIN_W   = 24;
  localparam int DB_W     = 16;
  localparam int PEAK_W   = 20;
  localparam int SC_W     = 32;
  localparam int MODE_W   = 3;

  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
  localparam logic [GAIN_W-1:0] UNITY_GAIN =
    (SCALE_FRAC_BITS >= GAIN_W) ? GAIN_MAX : GAIN_W'(1) << SCALE_FRAC_BITS;

  // log2(10)/20 in Q32
  localparam logic [30:0] LOG2_TEN_Q32 = 31'd713378626;
  localparam int PROD_W    = DB_W + 31;
  localparam int EXP_SPLIT = 32 + DB_FRAC_BITS;
  localparam int N_W       = PROD_W - EXP_SPLIT;

  localparam int MANT_STEPS = 30;
  localparam int MANT_W     = 32;
  localparam logic [MANT_W-1:0] MANT_ONE = MANT_W'(1) << 30;

  // soundcheck: raw at or above this saturates; below it the quotient fits
  localparam longint unsigned SC_SAT_RAW =
    ((64'd1 << GAIN_W) * 64'd1000 - 64'd500 + (64'd1 << SCALE_FRAC_BITS) - 64'd1)
    >> SCALE_FRAC_BITS;
  localparam int SC_M_W          = 31;
  localparam logic [31:0] SC_RECIP = 32'd2199023256;  // ceil(2^38 / 125)
  localparam int SC_RECIP_SHIFT  = 38;
  localparam int SC_PROD_W       = SC_M_W + 32;

  localparam int ONE_W = SCALE_FRAC_BITS + 17;
  localparam logic [ONE_W-1:0] PEAK_ONE = {1'b1, {(SCALE_FRAC_BITS + 16){1'b0}}};
  localparam int DIV_BITS = GAIN_W;
  localparam int LIM_W    = GAIN_W + PEAK_W;

  localparam int LATENCY = 3 + MANT_STEPS + 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE        = 3'd0,
    MODE_VOLUME      = 3'd1,
    MODE_SOUNDCHECK  = 3'd2,
    MODE_TRACK       = 3'd3,
    MODE_TRACK_PEAK  = 3'd4,
    MODE_ALBUM       = 3'd5,
    MODE_ALBUM_PEAK  = 3'd6
  } rgsr_mode_e;

  typedef struct packed {
    logic                volume_present;
    logic [GAIN_W-1:0]   volume_scale;
    logic                soundcheck_present;
    logic [SC_W-1:0]     soundcheck_field;
    logic                track_gain_present;
    logic [DB_W-1:0]     track_gain_db;
    logic                track_peak_present;
    logic [PEAK_W-1:0]   track_peak;
    logic                album_gain_present;
    logic [DB_W-1:0]     album_gain_db;
    logic                album_peak_present;
    logic [PEAK_W-1:0]   album_peak;
  } rgsr_in_t;

  typedef struct packed {
    logic                is_db;
    logic [31:0]         frac;
    logic [N_W-1:0]      n_int;
    logic [MANT_W-1:0]   mant;
    logic [GAIN_W-1:0]   fix_gain;
    logic                limit_en;
    logic [PEAK_W-1:0]   peak;
    logic [ONE_W-1:0]    rem;
    logic [DIV_BITS-1:0] quo;
    logic                div_sat;
  } rgsr_work_t;

  // r_0 = 2.0 in Q30, r_i = isqrt(r_{i-1} << 30); elaboration only
  function automatic logic [MANT_W-1:0] rgsr_root(input int idx);
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] q;
    logic [63:0] b;
    r = 64'd1 << 31;
    for (int i = 1; i <= idx; i++) begin
      v = r << 30;
      q = '0;
      b = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
        if (v >= q + b) begin
          v = v - (q + b);
          q = (q >> 1) + b;
        end else begin
          q = q >> 1;
        end
        b = b >> 2;
      end
      r = q;
    end
    return r[MANT_W-1:0];
  endfunction

endpackage

>>> sv/rgsr_front.sv
module rgsr_front
  import rgsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [MODE_W-1:0] mode_i,
  input  rgsr_in_t          in_i,
  output logic              valid_o,
  output rgsr_work_t        work_o
);

  logic en, use_sc, use_track, use_album, use_peak;
  logic album_hit, track_hit, sc_hit;
  logic [GAIN_W-1:0] fix_sel;
  logic [PEAK_W-1:0] peak_sel;
  logic [63:0]       sc_num;

  always_comb begin
    en = 1'b1; use_sc = 1'b0; use_track = 1'b0; use_album = 1'b0; use_peak = 1'b0;
    unique case (mode_i)
      MODE_NONE:       en = 1'b0;
      MODE_VOLUME:     ;
      MODE_SOUNDCHECK: use_sc = 1'b1;
      MODE_TRACK:      begin use_sc = 1'b1; use_track = 1'b1; end
      MODE_TRACK_PEAK: begin use_sc = 1'b1; use_track = 1'b1; use_peak = 1'b1; end
      MODE_ALBUM:      begin use_sc = 1'b1; use_track = 1'b1; use_album = 1'b1; end
      MODE_ALBUM_PEAK: begin
        use_sc = 1'b1; use_track = 1'b1; use_album = 1'b1; use_peak = 1'b1;
      end
      default:         en = 1'b0;
    endcase
  end

  always_comb begin
    fix_sel   = (en && in_i.volume_present) ? in_i.volume_scale : UNITY_GAIN;
    sc_hit    = en && use_sc && in_i.soundcheck_present && (in_i.soundcheck_field != '0);
    album_hit = en && use_album && in_i.album_gain_present;
    track_hit = en && use_track && in_i.track_gain_present;
    if (en && use_album && in_i.album_peak_present) begin
      peak_sel = in_i.album_peak;
    end else if (en && use_track && in_i.track_peak_present) begin
      peak_sel = in_i.track_peak;
    end else begin
      peak_sel = '0;
    end
    sc_num = (64'(in_i.soundcheck_field) << SCALE_FRAC_BITS) + 64'd500;
  end

  // stage 1: source selection
  logic                v1_q;
  logic                is_db1_q, sc_hit1_q, sc_sat1_q, limit1_q;
  logic [GAIN_W-1:0]   fix1_q;
  logic [SC_M_W-1:0]   sc_m1_q;
  logic [DB_W-1:0]     db1_q;
  logic [PEAK_W-1:0]   peak1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    is_db1_q  <= album_hit || track_hit;
    sc_hit1_q <= sc_hit;
    sc_sat1_q <= 64'(in_i.soundcheck_field) >= SC_SAT_RAW;
    limit1_q  <= en && use_peak && (peak_sel != '0);
    fix1_q    <= fix_sel;
    sc_m1_q   <= sc_num[SC_M_W+2:3];
    db1_q     <= album_hit ? in_i.album_gain_db : in_i.track_gain_db;
    peak1_q   <= peak_sel;
  end

  // stage 2: multiplies and divider setup
  logic                      v2_q;
  logic                      is_db2_q, sc_hit2_q, sc_sat2_q, limit2_q, dsat2_q;
  logic [GAIN_W-1:0]         fix2_q;
  logic [SC_PROD_W-1:0]      sc_prod2_q;
  logic signed [PROD_W-1:0]  db_prod2_q;
  logic [PEAK_W-1:0]         peak2_q;
  logic [ONE_W-1:0]          rem2_q;
  logic [ONE_W-1:0]          num_d;

  assign num_d = PEAK_ONE + ONE_W'(peak1_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    is_db2_q   <= is_db1_q;
    sc_hit2_q  <= sc_hit1_q;
    sc_sat2_q  <= sc_sat1_q;
    limit2_q   <= limit1_q;
    fix2_q     <= fix1_q;
    sc_prod2_q <= SC_PROD_W'(sc_m1_q) * SC_PROD_W'(SC_RECIP);
    db_prod2_q <= $signed({{(PROD_W-DB_W){db1_q[DB_W-1]}}, db1_q}) *
                  $signed(PROD_W'(LOG2_TEN_Q32));
    peak2_q    <= peak1_q;
    rem2_q     <= num_d;
    dsat2_q    <= LIM_W'(num_d) >= (LIM_W'(peak1_q) << DIV_BITS);
  end

  // stage 3: merge fixed sources, split log2 into integer and fraction
  logic       v3_q;
  rgsr_work_t work_q;
  rgsr_work_t work_d;

  always_comb begin
    work_d.is_db    = is_db2_q;
    work_d.frac     = db_prod2_q[EXP_SPLIT-1:DB_FRAC_BITS];
    work_d.n_int    = db_prod2_q[PROD_W-1:EXP_SPLIT];
    work_d.mant     = MANT_ONE;
    work_d.fix_gain = fix2_q;
    if (sc_hit2_q) begin
      work_d.fix_gain = sc_sat2_q ? GAIN_MAX : sc_prod2_q[SC_RECIP_SHIFT +: GAIN_W];
    end
    work_d.limit_en = limit2_q;
    work_d.peak     = peak2_q;
    work_d.rem      = rem2_q;
    work_d.quo      = '0;
    work_d.div_sat  = dsat2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign valid_o = v3_q;
  assign work_o  = work_q;

endmodule

>>> sv/rgsr_core.sv
module rgsr_core
  import rgsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  rgsr_work_t work_i,
  output logic       valid_o,
  output rgsr_work_t work_o
);

  // one root multiply per stage; one quotient bit per stage up to DIV_BITS
  rgsr_work_t stg_q   [1:MANT_STEPS];
  logic       stg_v_q [1:MANT_STEPS];

  for (genvar gi = 1; gi <= MANT_STEPS; gi++) begin : g_stage
    localparam logic [MANT_W-1:0] Root = rgsr_root(gi);
    rgsr_work_t          prev;
    rgsr_work_t          nxt;
    logic                prev_v;
    logic [63:0]         mprod;
    logic [63:0]         mrnd;
    logic [MANT_W-1:0]   mant_n;
    logic [ONE_W-1:0]    rem_n;
    logic [DIV_BITS-1:0] quo_n;

    if (gi == 1) begin : g_first
      assign prev   = work_i;
      assign prev_v = valid_i;
    end else begin : g_next
      assign prev   = stg_q[gi-1];
      assign prev_v = stg_v_q[gi-1];
    end

    always_comb begin
      mprod  = 64'(prev.mant) * 64'(Root);
      mrnd   = (mprod + (64'd1 << 29)) >> 30;
      mant_n = prev.frac[32-gi] ? mrnd[MANT_W-1:0] : prev.mant;
    end

    if (gi <= DIV_BITS) begin : g_div
      localparam int Bit = DIV_BITS - gi;
      logic [LIM_W-1:0] trial;
      always_comb begin
        trial = LIM_W'(prev.peak) << Bit;
        rem_n = prev.rem;
        quo_n = prev.quo;
        if (LIM_W'(prev.rem) >= trial) begin
          rem_n      = prev.rem - trial[ONE_W-1:0];
          quo_n[Bit] = 1'b1;
        end
      end
    end else begin : g_nodiv
      assign rem_n = prev.rem;
      assign quo_n = prev.quo;
    end

    always_comb begin
      nxt      = prev;
      nxt.mant = mant_n;
      nxt.rem  = rem_n;
      nxt.quo  = quo_n;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_v_q[gi] <= 1'b0;
      end else begin
        stg_v_q[gi] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[gi] <= nxt;
    end
  end

  assign valid_o = stg_v_q[MANT_STEPS];
  assign work_o  = stg_q[MANT_STEPS];

endmodule

>>> sv/rgsr_back.sv
module rgsr_back
  import rgsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rgsr_work_t        work_i,
  output logic              valid_o,
  output logic [GAIN_W-1:0] gain_o,
  output logic              limited_o
);

  // stage 1: scale the mantissa by 2^(n + frac bits - 30)
  logic signed [N_W+6:0] s_val;
  logic [N_W+6:0]        t_val;
  logic [5:0]            t6;
  logic [63:0]           sum;
  logic [63:0]           shr;
  logic [GAIN_W-1:0]     db_gain;

  always_comb begin
    s_val = (N_W+7)'($signed(work_i.n_int)) + (N_W+7)'(SCALE_FRAC_BITS - 30);
    t_val = -s_val;
    t6    = t_val[5:0];
    sum   = 64'(work_i.mant) + (64'd1 << (t6 - 6'd1));
    shr   = sum >> t6;
    if (!s_val[N_W+6]) begin
      db_gain = GAIN_MAX;
    end else if (t_val > (N_W+7)'(62)) begin
      db_gain = '0;
    end else begin
      db_gain = (shr > 64'(GAIN_MAX)) ? GAIN_MAX : shr[GAIN_W-1:0];
    end
  end

  logic                v1_q, lim1_q, dsat1_q;
  logic [GAIN_W-1:0]   gain1_q;
  logic [PEAK_W-1:0]   peak1_q;
  logic [DIV_BITS-1:0] quo1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    gain1_q <= work_i.is_db ? db_gain : work_i.fix_gain;
    lim1_q  <= work_i.limit_en;
    dsat1_q <= work_i.div_sat;
    peak1_q <= work_i.peak;
    quo1_q  <= work_i.quo;
  end

  // stage 2: gain times peak
  logic                v2_q, lim2_q, dsat2_q;
  logic [GAIN_W-1:0]   gain2_q;
  logic [LIM_W-1:0]    prod2_q;
  logic [DIV_BITS-1:0] quo2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    gain2_q <= gain1_q;
    lim2_q  <= lim1_q;
    dsat2_q <= dsat1_q;
    quo2_q  <= quo1_q;
    prod2_q <= LIM_W'(gain1_q) * LIM_W'(peak1_q);
  end

  // stage 3: clip to 1/peak when limiting is on and gain*peak exceeds unity
  logic              over;
  logic              v3_q, lim3_q;
  logic [GAIN_W-1:0] gain3_q;

  assign over = lim2_q && (prod2_q > LIM_W'(PEAK_ONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q   <= 1'b0;
      lim3_q <= 1'b0;
    end else begin
      v3_q   <= v2_q;
      lim3_q <= v2_q && over;
    end
  end

  always_ff @(posedge clk_i) begin
    gain3_q <= over ? (dsat2_q ? GAIN_MAX : quo2_q) : gain2_q;
  end

  assign valid_o   = v3_q;
  assign gain_o    = gain3_q;
  assign limited_o = lim3_q;

endmodule

>>> sv/replay_gain_scale_resolver_unit.sv
// Replay gain scale resolver: turns one track's loudness metadata into a
// linear playback gain (unsigned Q8.16, saturating) plus a peak-limit flag.
//
// Item channel: drive the metadata fields and pulse start_i; an item is
// taken at each rising edge where start_i is high and busy_o is low. busy_o
// is always low: the block is a fixed pipeline and takes one item per cycle.
//
// Result channel: result_valid_o is high for exactly one cycle with
// gain_scale_o and peak_limited_o; there is no backpressure, so the receiver
// must take it. Results come out in order, after 3 front stages (select,
// multiply, merge), 30 stages of the 2^frac product (one root multiply each)
// with the 1/peak restoring divider riding along one quotient bit per stage
// for the first DIV_BITS stages, and 3 back stages (shift, gain*peak, clip).
//
// Config: cfg_data_i holds scaling_mode; written when cfg_valid_i and
// cfg_ready_o are high (ready is always high). Change it only while idle.
//
// Reset (rst_ni low, async) clears the mode to none and drops every item
// in flight; nothing is emitted until new items arrive.
module replay_gain_scale_resolver_unit
  import rgsr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [MODE_W-1:0]        cfg_data_i,
  input  logic                     volume_present_i,
  input  logic [GAIN_W-1:0]        volume_scale_i,
  input  logic                     soundcheck_present_i,
  input  logic [SC_W-1:0]          soundcheck_field_i,
  input  logic                     track_gain_present_i,
  input  logic signed [DB_W-1:0]   track_gain_db_i,
  input  logic                     track_peak_present_i,
  input  logic [PEAK_W-1:0]        track_peak_i,
  input  logic                     album_gain_present_i,
  input  logic signed [DB_W-1:0]   album_gain_db_i,
  input  logic                     album_peak_present_i,
  input  logic [PEAK_W-1:0]        album_peak_i,
  output logic                     result_valid_o,
  output logic [GAIN_W-1:0]        gain_scale_o,
  output logic                     peak_limited_o
);

  // mode register
  logic [MODE_W-1:0] mode_q, mode_d;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign mode_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
    end else begin
      mode_q <= mode_d;
    end
  end

  // pack the item fields
  rgsr_in_t in_item;

  always_comb begin
    in_item.volume_present     = volume_present_i;
    in_item.volume_scale       = volume_scale_i;
    in_item.soundcheck_present = soundcheck_present_i;
    in_item.soundcheck_field   = soundcheck_field_i;
    in_item.track_gain_present = track_gain_present_i;
    in_item.track_gain_db      = track_gain_db_i;
    in_item.track_peak_present = track_peak_present_i;
    in_item.track_peak         = track_peak_i;
    in_item.album_gain_present = album_gain_present_i;
    in_item.album_gain_db      = album_gain_db_i;
    in_item.album_peak_present = album_peak_present_i;
    in_item.album_peak         = album_peak_i;
  end

  logic       front_v, core_v;
  rgsr_work_t front_w, core_w;

  // source selection, soundcheck divide by 1000, dB -> log2 product
  rgsr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .mode_i  (mode_q),
    .in_i    (in_item),
    .valid_o (front_v),
    .work_o  (front_w)
  );

  // 2^frac mantissa and 1/peak quotient
  rgsr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_v),
    .work_i  (front_w),
    .valid_o (core_v),
    .work_o  (core_w)
  );

  // exponent shift, peak compare, output register
  rgsr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (core_v),
    .work_i    (core_w),
    .valid_o   (result_valid_o),
    .gain_o    (gain_scale_o),
    .limited_o (peak_limited_o)
  );

  a_strobe_from_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result strobe without matching item");

  a_limit_in_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_limited_o |-> result_valid_o)
    else $error("peak_limited outside result strobe");

  a_limited_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && peak_limited_o) |-> (gain_scale_o != '0))
    else $error("peak-limited gain is zero");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rgsr_pkg::*;

  // Undefined mode code, expected to behave like none
  localparam logic [MODE_W-1:0] MODE_UNDEF = 3'd7;

  // Clock, reset and block ports
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [MODE_W-1:0] cfg_data_i = '0;
  logic volume_present_i = 1'b0;
  logic [GAIN_W-1:0] volume_scale_i = '0;
  logic soundcheck_present_i = 1'b0;
  logic [SC_W-1:0] soundcheck_field_i = '0;
  logic track_gain_present_i = 1'b0;
  logic signed [DB_W-1:0] track_gain_db_i = '0;
  logic track_peak_present_i = 1'b0;
  logic [PEAK_W-1:0] track_peak_i = '0;
  logic album_gain_present_i = 1'b0;
  logic signed [DB_W-1:0] album_gain_db_i = '0;
  logic album_peak_present_i = 1'b0;
  logic [PEAK_W-1:0] album_peak_i = '0;
  logic result_valid_o;
  logic [GAIN_W-1:0] gain_scale_o;
  logic peak_limited_o;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              limited;
  } gain_result_t;

  // Predictor's copy of the mode register
  logic [MODE_W-1:0] cur_mode = MODE_NONE;
  gain_result_t pending_gains[$];
  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_limited = 0;

  always #5 clk_i = ~clk_i;

  replay_gain_scale_resolver_unit i_dut (.*);

  function automatic logic [63:0] sat_gain(input logic [63:0] v);
    return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // dB (Q8.8) to linear Q8.16: log2 split, 2^frac by square-root ladder
  function automatic logic [63:0] db_to_linear(input logic signed [DB_W-1:0] db);
    longint prod;
    logic [63:0] u;
    logic [63:0] f;
    logic [63:0] m;
    logic [63:0] r;
    longint n;
    longint s;
    prod = longint'(db) * 64'sd713378626;
    u = prod + (64'sd512 <<< (32 + DB_FRAC_BITS));
    n = longint'(u >> (32 + DB_FRAC_BITS)) - 512;
    f = (u >> DB_FRAC_BITS) & 64'hFFFF_FFFF;
    m = 64'd1 << 30;
    r = 64'd1 << 31;
    for (int i = 1; i <= 30; i++) begin
      r = int_sqrt(r << 30);
      if (f[32-i]) m = (m * r + (64'd1 << 29)) >> 30;
    end
    s = n + SCALE_FRAC_BITS - 30;
    if (s >= 0) begin
      if (s > 32) return 64'hFFFFFF;
      return sat_gain(m << s);
    end
    if (-s > 62) return 64'd0;
    return sat_gain((m + (64'd1 << (-s - 1))) >> (-s));
  endfunction

  function automatic gain_result_t predict_gain(input rgsr_in_t it,
                                                input logic [MODE_W-1:0] mode);
    gain_result_t res;
    logic [63:0] g;
    logic [63:0] pk;
    logic [63:0] one;
    g = 64'd1 << SCALE_FRAC_BITS;
    pk = 64'd0;
    one = 64'd1 << (SCALE_FRAC_BITS + 16);
    res.limited = 1'b0;
    // mode seven is undefined and falls back to unity like none
    if (mode inside {MODE_VOLUME, MODE_SOUNDCHECK, MODE_TRACK, MODE_TRACK_PEAK,
                     MODE_ALBUM, MODE_ALBUM_PEAK}) begin
      if (it.volume_present) g = 64'(it.volume_scale);
      if (mode >= MODE_SOUNDCHECK && it.soundcheck_present && it.soundcheck_field != 0)
        g = sat_gain(((64'(it.soundcheck_field) << SCALE_FRAC_BITS) + 500) / 1000);
      if (mode >= MODE_TRACK) begin
        if (it.track_gain_present) g = db_to_linear(it.track_gain_db);
        if (it.track_peak_present) pk = 64'(it.track_peak);
      end
      if (mode >= MODE_ALBUM) begin
        if (it.album_gain_present) g = db_to_linear(it.album_gain_db);
        if (it.album_peak_present) pk = 64'(it.album_peak);
      end
      if ((mode == MODE_TRACK_PEAK || mode == MODE_ALBUM_PEAK) && pk != 0 &&
          g * pk > one) begin
        g = sat_gain((one + pk / 2) / pk);
        res.limited = 1'b1;
      end
    end
    res.gain = g[GAIN_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_v);
    n_errors++;
    $display("ERROR t=%0t %s: got %0h, expected %0h", $realtime, what, got, exp_v);
  endtask

  // Result checker: every strobe is matched against the oldest prediction
  always @(posedge clk_i) begin
    gain_result_t want;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (pending_gains.size() == 0) begin
        report_mismatch("unexpected result", 64'(gain_scale_o), 64'd0);
      end else begin
        want = pending_gains.pop_front();
        if (want.limited) n_limited++;
        if (gain_scale_o !== want.gain)
          report_mismatch("gain_scale", 64'(gain_scale_o), 64'(want.gain));
        if (peak_limited_o !== want.limited)
          report_mismatch("peak_limited", 64'(peak_limited_o), 64'(want.limited));
      end
    end
  end

  // Send one item after an optional random gap; predict at the accepting edge
  task automatic send_item(input rgsr_in_t it, input bit allow_gap = 1'b1);
    int gap;
    gap = allow_gap ? $urandom_range(0, 10) : 0;
    // occasionally force no gap before an item
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    volume_present_i <= it.volume_present;
    volume_scale_i <= it.volume_scale;
    soundcheck_present_i <= it.soundcheck_present;
    soundcheck_field_i <= it.soundcheck_field;
    track_gain_present_i <= it.track_gain_present;
    track_gain_db_i <= it.track_gain_db;
    track_peak_present_i <= it.track_peak_present;
    track_peak_i <= it.track_peak;
    album_gain_present_i <= it.album_gain_present;
    album_gain_db_i <= it.album_gain_db;
    album_peak_present_i <= it.album_peak_present;
    album_peak_i <= it.album_peak;
    do @(posedge clk_i); while (busy_o);
    pending_gains.push_back(predict_gain(it, cur_mode));
    n_items++;
  endtask

  task automatic stop_sending();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for all results, then let the pipe drain before a mode change
  task automatic wait_drained();
    stop_sending();
    while (pending_gains.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_mode = mode;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic rgsr_in_t random_item();
    rgsr_in_t it;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(rgsr_in_t)-1:0];
    // bias values toward interesting ranges
    case ($urandom_range(0, 3))
      0: it.track_gain_db = DB_W'($urandom_range(0, 8000) - 4000);  // +-15.6 dB
      1: it.track_gain_db = DB_W'($urandom_range(0, 12288) - 6144);
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: it.album_gain_db = DB_W'($urandom_range(0, 8000) - 4000);
      1: it.album_gain_db = DB_W'($urandom_range(0, 12288) - 6144);
      default: ;
    endcase
    if ($urandom_range(0, 1)) it.track_peak = PEAK_W'($urandom_range(0, 2 * 65536));
    if ($urandom_range(0, 1)) it.album_peak = PEAK_W'($urandom_range(0, 2 * 65536));
    if ($urandom_range(0, 2) == 0) it.soundcheck_field = $urandom_range(0, 4000);
    if ($urandom_range(0, 7) == 0) it.soundcheck_field = '0;
    if ($urandom_range(0, 7) == 0) it.track_peak = '0;
    return it;
  endfunction

  // Directed corners: field extremes, zero peaks, soundcheck zero, dB limits
  task automatic test_directed();
    rgsr_in_t it;
    logic [MODE_W-1:0] modes[4] = '{MODE_NONE, MODE_UNDEF, MODE_TRACK_PEAK,
                                    MODE_ALBUM_PEAK};
    foreach (modes[k]) begin
      write_mode(modes[k]);
      it = '1;
      send_item(it);
      it.track_gain_db = 16'sh7FFF;
      it.album_gain_db = 16'sh8000;
      send_item(it);
      it = '0;
      it.track_gain_present = 1'b1;
      it.track_peak_present = 1'b1;  // zero peak still overrides
      it.album_peak_present = 1'b1;
      it.album_peak = '1;
      send_item(it);
      it = '0;
      it.soundcheck_present = 1'b1;  // raw zero leaves volume
      it.volume_present = 1'b1;
      it.volume_scale = 24'h00ABCD;
      send_item(it);
      it.soundcheck_field = '1;
      send_item(it);
      wait_drained();
    end
  endtask

  // Random items across every mode
  task automatic test_random_modes();
    logic [MODE_W-1:0] seq[8] = '{MODE_VOLUME, MODE_SOUNDCHECK, MODE_TRACK,
      MODE_TRACK_PEAK, MODE_ALBUM, MODE_ALBUM_PEAK, MODE_UNDEF, MODE_NONE};
    foreach (seq[k]) begin
      write_mode(seq[k]);
      repeat (220) send_item(random_item());
      wait_drained();
    end
  endtask

  // Back-to-back items with mid-run pauses until fully drained
  task automatic test_burst();
    write_mode(MODE_ALBUM_PEAK);
    repeat (3) begin
      repeat (30) send_item(random_item(), 1'b0);
      stop_sending();
      while (pending_gains.size() != 0) @(posedge clk_i);
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_modes();
    test_burst();
    $display("Covered %0d items, %0d results (%0d peak limited) over all modes.",
             n_items, n_results, n_limited);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
sv/rgsr_pkg.sv
sv/rgsr_front.sv
sv/rgsr_core.sv
sv/rgsr_back.sv
sv/replay_gain_scale_resolver_unit.sv
dv/tb_top.sv
